// ===== rtl/core/lzrd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzrd_pkg
// Shared types and constants of the LZ/RLE/delta decoder.
// ----------------------------------------------------------------------------
package lzrd_pkg;

  localparam int HISTORY_DEPTH_DEF    = 16384;
  localparam int BYTES_PER_RESULT_DEF = 8;
  localparam int QUEUE_DEPTH          = 2;

  // Operation codes, decided by the front end.
  typedef enum logic [2:0] {
    OP_END,
    OP_LITERAL,
    OP_COPY,
    OP_BYTE_DELTA,
    OP_WORD_DELTA,
    OP_BYTE_REPEAT,
    OP_WORD_REPEAT
  } op_t;

  // One operation handed from the front end to the back end.
  typedef struct packed {
    op_t         op;
    logic [7:0]  lit;       // literal byte
    logic [13:0] distance;  // copy distance, 3..8194
    logic [8:0]  len;       // bytes for copies and byte ops, words for word ops
  } cmd_t;

  typedef enum logic [2:0] {
    PH_COMMAND,
    PH_MEDIUM_DIST,
    PH_LONG_DIST,
    PH_LONG_LEN,
    PH_LITERAL
  } phase_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_FETCH,
    BS_WAIT,
    BS_PREP,
    BS_RUN,
    BS_FLUSH
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/lzrd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzrd_front
// Parses command, operand and literal bytes into operations.
// ----------------------------------------------------------------------------
module lzrd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_byte,
  output logic               cmd_valid,
  input  wire logic          cmd_stall,
  output lzrd_pkg::cmd_t     cmd
);

  lzrd_pkg::phase_t phase, phase_next;
  logic [7:0]       pending_command, pending_command_next;
  logic [13:0]      pending_distance, pending_distance_next;
  logic [5:0]       literal_remaining, literal_remaining_next;
  logic             emit;
  logic             take;

  assign in_stall = cmd_stall;
  assign take     = in_valid && !cmd_stall;
  assign cmd_valid = in_valid && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= lzrd_pkg::PH_COMMAND;
      pending_command   <= '0;
      pending_distance  <= '0;
      literal_remaining <= '0;
    end else if (take) begin
      phase             <= phase_next;
      pending_command   <= pending_command_next;
      pending_distance  <= pending_distance_next;
      literal_remaining <= literal_remaining_next;
    end
  end

  always_comb begin
    phase_next             = lzrd_pkg::PH_COMMAND;
    pending_command_next   = pending_command;
    pending_distance_next  = pending_distance;
    literal_remaining_next = literal_remaining;
    emit                   = 1'b0;
    cmd.op                 = lzrd_pkg::OP_LITERAL;
    cmd.lit                = in_byte;
    cmd.distance           = '0;
    cmd.len                = '0;
    case (phase)
      lzrd_pkg::PH_MEDIUM_DIST: begin
        emit         = 1'b1;
        cmd.op       = lzrd_pkg::OP_COPY;
        cmd.distance = {4'b0, pending_command[1:0], in_byte} + 14'd3;
        cmd.len      = {6'b0, pending_command[4:2]} + 9'd4;
      end
      lzrd_pkg::PH_LONG_DIST: begin
        pending_distance_next = {1'b0, pending_command[4:0], in_byte} + 14'd3;
        phase_next            = lzrd_pkg::PH_LONG_LEN;
      end
      lzrd_pkg::PH_LONG_LEN: begin
        emit         = 1'b1;
        cmd.op       = lzrd_pkg::OP_COPY;
        cmd.distance = pending_distance;
        cmd.len      = {1'b0, in_byte} + 9'd5;
      end
      lzrd_pkg::PH_LITERAL: begin
        emit = 1'b1;
        literal_remaining_next = literal_remaining - 6'd1;
        if (literal_remaining != 6'd1) phase_next = lzrd_pkg::PH_LITERAL;
      end
      default: begin
        if (in_byte == 8'd0) begin
          emit   = 1'b1;
          cmd.op = lzrd_pkg::OP_END;
        end else if (in_byte[7]) begin
          if (!in_byte[6]) begin
            emit         = 1'b1;
            cmd.op       = lzrd_pkg::OP_COPY;
            cmd.distance = {8'b0, in_byte[5:0]} + 14'd3;
            cmd.len      = 9'd3;
          end else begin
            pending_command_next = in_byte;
            phase_next = in_byte[5] ? lzrd_pkg::PH_LONG_DIST : lzrd_pkg::PH_MEDIUM_DIST;
          end
        end else if (in_byte[6]) begin
          emit = 1'b1;
          case (in_byte[5:4])
            2'b00:   cmd.op = lzrd_pkg::OP_BYTE_DELTA;
            2'b01:   cmd.op = lzrd_pkg::OP_WORD_DELTA;
            2'b10:   cmd.op = lzrd_pkg::OP_BYTE_REPEAT;
            default: cmd.op = lzrd_pkg::OP_WORD_REPEAT;
          endcase
          cmd.len = {5'b0, in_byte[3:0]} + (in_byte[4] ? 9'd2 : 9'd3);
        end else begin
          literal_remaining_next = in_byte[5:0];
          phase_next             = lzrd_pkg::PH_LITERAL;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/lzrd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzrd_queue
// Small FIFO of operations between the front and back ends.
// ----------------------------------------------------------------------------
module lzrd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_valid,
  output logic                 wr_stall,
  input  wire lzrd_pkg::cmd_t  wr_cmd,
  output logic                 rd_valid,
  input  wire logic            rd_take,
  output lzrd_pkg::cmd_t       rd_cmd
);

  localparam int AW = $clog2(lzrd_pkg::QUEUE_DEPTH);

  lzrd_pkg::cmd_t   slots [lzrd_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [AW:0]      count;
  logic             push, pop;

  assign wr_stall = (count == (AW+1)'(lzrd_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + AW'(1);
      if (pop)  rptr <= rptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wr_cmd;
  end

endmodule
`default_nettype wire

// ===== rtl/core/lzrd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzrd_back
// Executes operations: history memory, byte generation, result packing.
// ----------------------------------------------------------------------------
module lzrd_back #(
  parameter int HISTORY_DEPTH    = lzrd_pkg::HISTORY_DEPTH_DEF,
  parameter int BYTES_PER_RESULT = lzrd_pkg::BYTES_PER_RESULT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_take,
  input  wire lzrd_pkg::cmd_t  cmd,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [63:0]          out_bytes,
  output logic [3:0]           byte_count,
  output logic                 run_last,
  output logic                 stream_end,
  output logic [31:0]          total_length
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int PW = $clog2(BYTES_PER_RESULT + 1);

  logic [7:0]     mem [HISTORY_DEPTH];
  logic [7:0]     rd_data;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wpos;
  logic [31:0]    total;

  lzrd_pkg::back_state_t state, state_next;
  lzrd_pkg::cmd_t        cur;
  logic [9:0]            remain;     // bytes still to produce
  logic [1:0]            fetch_idx;  // history bytes gathered for run ops
  logic [7:0]            h1, h2, h3, h4;
  logic [15:0]           acc, dlt;   // running value and step
  logic                  phase_hi;   // next byte is high half of a word
  logic [63:0]           pack;
  logic [PW-1:0]         plen;
  logic [7:0]            gen_byte;
  logic                  is_copy, run_active, need_flush;

  logic                  ov;
  logic [63:0]           ob;
  logic [3:0]            oc;
  logic                  ol, oe;
  logic [31:0]           ot;
  logic                  push_out;
  logic                  out_free;

  // history position d bytes behind p, wrapping at the history depth
  function automatic logic [AW-1:0] back_addr(logic [AW-1:0] p, logic [13:0] d);
    logic [AW:0] diff;
    diff = {1'b0, p} - (AW+1)'(d);
    if (diff[AW]) diff = diff + (AW+1)'(HISTORY_DEPTH);
    return diff[AW-1:0];
  endfunction

  assign out_valid = ov;
  assign out_bytes = ob;
  assign byte_count = oc;
  assign run_last = ol;
  assign stream_end = oe;
  assign total_length = ot;
  assign out_free = !ov || !out_stall;
  assign is_copy = (cur.op == lzrd_pkg::OP_COPY);

  // history memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wpos] <= gen_byte;
    rd_data <= mem[rd_addr];
  end

  // byte produced this run cycle
  always_comb begin
    case (cur.op)
      lzrd_pkg::OP_LITERAL:     gen_byte = cur.lit;
      lzrd_pkg::OP_COPY:        gen_byte = rd_data;
      lzrd_pkg::OP_BYTE_REPEAT: gen_byte = h1;
      lzrd_pkg::OP_WORD_REPEAT: gen_byte = phase_hi ? h1 : h2;
      lzrd_pkg::OP_BYTE_DELTA:  gen_byte = acc[7:0] + dlt[7:0];
      lzrd_pkg::OP_WORD_DELTA:  gen_byte = phase_hi ? acc[15:8] : acc[7:0];
      default:                  gen_byte = 8'd0;
    endcase
  end

  // the copy source runs one byte ahead of the write position while bytes
  // advance, and rereads the current byte while the output holds; overlapping
  // copies one byte apart are not possible since distance is at least 3
  always_comb begin
    if (state == lzrd_pkg::BS_FETCH && !is_copy) begin
      rd_addr = back_addr(wpos, 14'd1);
    end else if (state == lzrd_pkg::BS_WAIT && !is_copy) begin
      rd_addr = back_addr(wpos, 14'({1'b0, fetch_idx} + 3'd2));
    end else if (run_active) begin
      rd_addr = back_addr(wpos, cur.distance - 14'd1);
    end else begin
      rd_addr = back_addr(wpos, cur.distance);
    end
  end

  assign run_active = (state == lzrd_pkg::BS_RUN) && out_free;
  assign wr_en      = run_active;
  assign need_flush = (plen == PW'(BYTES_PER_RESULT - 1)) || (remain == 10'd1);
  assign push_out   = run_active && need_flush;

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    case (state)
      lzrd_pkg::BS_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take = 1'b1;
          case (cmd.op)
            lzrd_pkg::OP_END:     state_next = lzrd_pkg::BS_IDLE;
            lzrd_pkg::OP_LITERAL: state_next = lzrd_pkg::BS_RUN;
            default:              state_next = lzrd_pkg::BS_FETCH;
          endcase
        end
      end
      lzrd_pkg::BS_FETCH: state_next = lzrd_pkg::BS_WAIT;
      lzrd_pkg::BS_WAIT: begin
        if (is_copy || fetch_idx == 2'd3) state_next = lzrd_pkg::BS_PREP;
        else                              state_next = lzrd_pkg::BS_WAIT;
      end
      lzrd_pkg::BS_PREP: state_next = lzrd_pkg::BS_RUN;
      lzrd_pkg::BS_RUN: begin
        if (run_active && remain == 10'd1) state_next = lzrd_pkg::BS_IDLE;
      end
      default: state_next = lzrd_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzrd_pkg::BS_IDLE;
      wpos  <= '0;
      total <= '0;
      ov    <= 1'b0;
      plen  <= '0;
    end else begin
      state <= state_next;
      if ((cmd_take && cmd.op == lzrd_pkg::OP_END) || push_out) ov <= 1'b1;
      else if (!out_stall)                                     ov <= 1'b0;
      if (cmd_take && cmd.op == lzrd_pkg::OP_END) begin
        wpos  <= '0;
        total <= '0;
      end
      if (run_active) begin
        wpos <= (wpos == AW'(HISTORY_DEPTH - 1)) ? '0 : wpos + AW'(1);
        if (total != 32'hFFFF_FFFF) total <= total + 32'd1;
        plen <= need_flush ? '0 : plen + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur       <= cmd;
      fetch_idx <= '0;
      phase_hi  <= 1'b0;
      pack      <= '0;
      case (cmd.op)
        lzrd_pkg::OP_WORD_DELTA, lzrd_pkg::OP_WORD_REPEAT: remain <= {cmd.len, 1'b0};
        lzrd_pkg::OP_LITERAL: remain <= 10'd1;
        default:              remain <= {1'b0, cmd.len};
      endcase
      if (cmd.op == lzrd_pkg::OP_END) begin
        ob <= '0;
        oc <= '0;
        ol <= 1'b1;
        oe <= 1'b1;
        ot <= total;
      end
    end
    if (state == lzrd_pkg::BS_WAIT && !is_copy) begin
      fetch_idx <= fetch_idx + 2'd1;
      case (fetch_idx)
        2'd0:    h1 <= rd_data;
        2'd1:    h2 <= rd_data;
        2'd2:    h3 <= rd_data;
        default: h4 <= rd_data;
      endcase
    end
    if (state == lzrd_pkg::BS_PREP) begin
      if (cur.op == lzrd_pkg::OP_WORD_DELTA) begin
        dlt <= {h1, h2} - {h3, h4};
        acc <= {h1, h2} + ({h1, h2} - {h3, h4});
      end else begin
        dlt <= {8'd0, h1 - h2};
        acc <= {8'd0, h1};
      end
    end
    if (run_active) begin
      remain   <= remain - 10'd1;
      phase_hi <= !phase_hi;
      if (cur.op == lzrd_pkg::OP_BYTE_DELTA) acc <= {8'd0, gen_byte};
      if (cur.op == lzrd_pkg::OP_WORD_DELTA && phase_hi) acc <= acc + dlt;
      if (need_flush) begin
        pack <= '0;
        ob   <= pack | ({56'd0, gen_byte} << {plen, 3'b000});
        oc   <= 4'(plen) + 4'd1;
        ol   <= (remain == 10'd1);
        oe   <= 1'b0;
        ot   <= '0;
      end else begin
        pack <= pack | ({56'd0, gen_byte} << {plen, 3'b000});
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lz_rle_delta_decompressor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lz_rle_delta_decompressor
// Byte-serial LZ77 decoder with byte/word repeat and delta runs.
// ----------------------------------------------------------------------------
// A byte enters whenever the two-entry operation queue has room. The back end
// writes one decoded byte per cycle into the history memory while the output
// is not stalled, and packs up to BYTES_PER_RESULT bytes per result. Every
// operation is taken from the queue in the idle state; a copy then passes the
// fetch, wait and prep states (history read latency) and a delta or repeat op
// also stays in wait until it has read four bytes back, before the run state
// writes its decoded bytes. A literal byte goes straight to the run state. The
// end byte gives one result with stream_end set and total_length. A stalled
// output holds the back end; the queue then fills and stalls the input.
module lz_rle_delta_decompressor #(
  parameter int HISTORY_DEPTH    = lzrd_pkg::HISTORY_DEPTH_DEF,
  parameter int BYTES_PER_RESULT = lzrd_pkg::BYTES_PER_RESULT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_bytes,
  output logic [3:0]       byte_count,
  output logic             run_last,
  output logic             stream_end,
  output logic [31:0]      total_length
);

  lzrd_pkg::cmd_t f_cmd, q_cmd;
  logic           f_valid, f_stall, q_valid, q_take;

  lzrd_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_byte,
    .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd)
  );

  lzrd_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_cmd(f_cmd),
    .rd_valid(q_valid), .rd_take(q_take), .rd_cmd(q_cmd)
  );

  lzrd_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH), .BYTES_PER_RESULT(BYTES_PER_RESULT)
  ) u_back (
    .clk, .rst,
    .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_cmd),
    .out_valid, .out_stall, .out_bytes, .byte_count,
    .run_last, .stream_end, .total_length
  );

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the LZ/RLE/delta decoder. A behavioral decoder predicts
// each packed result from the compressed bytes sent. Directed tests walk
// every command and its extremes, including the farthest copy distance.
// A random part sends well-formed commands whose references always land on
// written history. Both sides idle and stall in random bursts, and one long
// receiver hold fills the block up.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HIST_SIZE  = 16384;
  localparam int PACK_BYTES = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int RAND_ITEMS = 200;

  localparam logic [7:0] CMD_END        = 8'h00;
  localparam logic [7:0] CMD_BYTE_DELTA = 8'h40;
  localparam logic [7:0] CMD_WORD_DELTA = 8'h50;
  localparam logic [7:0] CMD_BYTE_REP   = 8'h60;
  localparam logic [7:0] CMD_WORD_REP   = 8'h70;
  localparam logic [7:0] CMD_SHORT_COPY = 8'h80;
  localparam logic [7:0] CMD_MED_COPY   = 8'hC0;
  localparam logic [7:0] CMD_LONG_COPY  = 8'hE0;

  typedef struct {
    logic [63:0] bytes;
    logic [3:0]  cnt;
    logic        last;
    logic        send;
    logic [31:0] tot;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        run_last;
  logic        stream_end;
  logic [31:0] total_length;

  lz_rle_delta_decompressor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_bytes(out_bytes),
    .byte_count(byte_count), .run_last(run_last), .stream_end(stream_end),
    .total_length(total_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Decoder model state
  logic [7:0]        hist [HIST_SIZE];
  bit                seen [HIST_SIZE];
  logic [13:0]       wpos = '0;
  logic [31:0]       dtotal = '0;
  lzrd_pkg::phase_t  phase = lzrd_pkg::PH_COMMAND;
  logic [7:0]        pcmd = '0;
  logic [13:0]       pdist = '0;
  logic [5:0]        lrem = '0;
  logic [63:0]       pbits;
  int                plen;
  int                nres;
  decoded_t          decoded_q[$];

  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  streams_ended = 0;
  int  hold_left = 0;
  bit  quiet = 1'b0;

  task automatic flush_pack();
    decoded_t r;
    r.bytes = pbits;
    r.cnt   = plen[3:0];
    r.last  = 1'b0;
    r.send  = 1'b0;
    r.tot   = '0;
    decoded_q.push_back(r);
    nres++;
    pbits = '0;
    plen  = 0;
  endtask

  task automatic put_byte(logic [7:0] b);
    hist[wpos] = b;
    seen[wpos] = 1'b1;
    wpos++;
    if (dtotal != 32'hFFFF_FFFF) dtotal++;
    pbits |= 64'(b) << (8 * plen);
    plen++;
    if (plen >= PACK_BYTES) flush_pack();
  endtask

  function automatic logic [7:0] hist_back(int d);
    return hist[wpos - d[13:0]];
  endfunction

  task automatic copy_back(int d, int n);
    for (int i = 0; i < n; i++) put_byte(hist_back(d));
  endtask

  // True when the d bytes behind the write position were all written.
  function automatic bit reach_ok(int d);
    for (int k = 1; k <= d; k++)
      if (!seen[wpos - k[13:0]]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic decode_byte(logic [7:0] c);
    logic [15:0] u, p, dw;
    logic [7:0]  ub, db, lo, hi;
    decoded_t    r;
    int          n;
    pbits = '0;
    plen  = 0;
    nres  = 0;
    case (phase)
      lzrd_pkg::PH_MEDIUM_DIST: begin
        phase = lzrd_pkg::PH_COMMAND;
        copy_back(((pcmd & 3) << 8) + c + 3, ((pcmd >> 2) & 7) + 4);
      end
      lzrd_pkg::PH_LONG_DIST: begin
        pdist = ((pcmd & 31) << 8) + c + 3;
        phase = lzrd_pkg::PH_LONG_LEN;
      end
      lzrd_pkg::PH_LONG_LEN: begin
        phase = lzrd_pkg::PH_COMMAND;
        copy_back(pdist, c + 5);
      end
      lzrd_pkg::PH_LITERAL: begin
        put_byte(c);
        if (lrem > 0) lrem--;
        if (lrem == 0) phase = lzrd_pkg::PH_COMMAND;
      end
      default: begin
        phase = lzrd_pkg::PH_COMMAND;
        if (c == CMD_END) begin
          r.bytes = '0;
          r.cnt   = '0;
          r.last  = 1'b1;
          r.send  = 1'b1;
          r.tot   = dtotal;
          decoded_q.push_back(r);
          wpos   = '0;
          dtotal = '0;
          return;
        end
        if (c[7]) begin
          if (!c[6]) copy_back((c & 63) + 3, 3);
          else begin
            pcmd  = c;
            phase = c[5] ? lzrd_pkg::PH_LONG_DIST : lzrd_pkg::PH_MEDIUM_DIST;
          end
        end else if (c[6]) begin
          if (c[5] && c[4]) begin
            lo = hist_back(2);
            hi = hist_back(1);
            n  = (c & 15) + 2;
            for (int i = 0; i < n; i++) begin
              put_byte(lo);
              put_byte(hi);
            end
          end else if (c[5]) begin
            lo = hist_back(1);
            n  = (c & 15) + 3;
            for (int i = 0; i < n; i++) put_byte(lo);
          end else if (c[4]) begin
            u  = {hist_back(1), hist_back(2)};
            p  = {hist_back(3), hist_back(4)};
            dw = u - p;
            n  = (c & 15) + 2;
            for (int i = 0; i < n; i++) begin
              u = u + dw;
              put_byte(u[7:0]);
              put_byte(u[15:8]);
            end
          end else begin
            ub = hist_back(1);
            db = ub - hist_back(2);
            n  = (c & 15) + 3;
            for (int i = 0; i < n; i++) begin
              ub = ub + db;
              put_byte(ub);
            end
          end
        end else begin
          lrem  = c[5:0];
          phase = lzrd_pkg::PH_LITERAL;
        end
      end
    endcase
    if (plen > 0) flush_pack();
    if (nres > 0) decoded_q[$].last = 1'b1;
  endtask

  // Offer one item after an optional idle burst; predict, then wait for it.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    decode_byte(b);
    items_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin
    decoded_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        $error("result with nothing expected: out_bytes %h", out_bytes);
        errors++;
      end else begin
        e = decoded_q.pop_front();
        if (byte_count !== e.cnt) begin
          $error("byte_count expected %0d actual %0d", e.cnt, byte_count);
          errors++;
        end
        if (out_bytes !== e.bytes) begin
          $error("out_bytes expected %h actual %h", e.bytes, out_bytes);
          errors++;
        end
        if (run_last !== e.last) begin
          $error("run_last expected %0d actual %0d", e.last, run_last);
          errors++;
        end
        if (stream_end !== e.send) begin
          $error("stream_end expected %0d actual %0d", e.send, stream_end);
          errors++;
        end
        if (total_length !== e.tot) begin
          $error("total_length expected %0d actual %0d", e.tot, total_length);
          errors++;
        end
        if (e.send) streams_ended++;
      end
    end
  end

  // Receiver stall: a long hold when asked, else random bursts unless quiet.
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("lz_rle_delta_decompressor regression: fail");
      $finish;
    end
  end

  task automatic test_each_command();
    logic [7:0] seq [] = '{CMD_END, 8'h04, 8'h00, 8'hFF, 8'h01, 8'h80,
                           CMD_BYTE_DELTA, 8'h4F, CMD_WORD_DELTA, 8'h5F,
                           CMD_BYTE_REP, 8'h6F, CMD_WORD_REP, 8'h7F,
                           CMD_SHORT_COPY, CMD_MED_COPY, 8'h00, 8'h01, 8'h7E};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_far_copies();
    send_byte(8'hBF);
    for (int i = 0; i < 32; i++) begin
      send_byte(CMD_LONG_COPY);
      send_byte(8'($urandom_range(0, 40)));
      send_byte(8'hFF);
    end
    send_byte(8'hDF);
    send_byte(8'hFF);
    send_byte(8'hC3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(CMD_LONG_COPY);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(CMD_END);
  endtask

  // Fill fresh history with a literal run, then hold the output while
  // short copies and word repeats keep coming.
  task automatic test_backpressure();
    send_byte(8'h20);
    for (int i = 0; i < 32; i++) send_byte(8'($urandom));
    hold_left = 400;
    for (int i = 0; i < 12; i++)
      send_byte(i[0] ? 8'h7F : (CMD_SHORT_COPY | 8'($urandom_range(0, 28))));
    send_byte(CMD_END);
  endtask

  // One well-formed command with random content; fall back to a literal run
  // when its reference would reach unwritten history.
  task automatic send_random_command();
    int sel, n, d;
    logic [7:0] c, b1, b2;
    sel = $urandom_range(0, 99);
    c   = 8'($urandom);
    b1  = 8'($urandom);
    b2  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
    if (sel < 38) begin
      c = CMD_BYTE_DELTA + 8'($urandom_range(0, 63));
      if (reach_ok(4)) begin send_byte(c); return; end
    end else if (sel < 58) begin
      c = CMD_SHORT_COPY | (c & 8'h3F);
      if (reach_ok((c & 63) + 3)) begin send_byte(c); return; end
    end else if (sel < 74) begin
      c = CMD_MED_COPY | (c & 8'h1F);
      if (reach_ok(((c & 3) << 8) + b1 + 3)) begin
        send_byte(c);
        send_byte(b1);
        return;
      end
    end else if (sel < 86) begin
      c = CMD_LONG_COPY | (c & 8'h1F);
      if ($urandom_range(0, 1)) c = c & 8'hE3;
      if (reach_ok(((c & 31) << 8) + b1 + 3)) begin
        send_byte(c);
        send_byte(b1);
        send_byte(b2);
        return;
      end
    end else if (sel < 90) begin
      send_byte(CMD_END);
      return;
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 6);
    send_byte(8'(n));
    for (int i = 0; i < n; i++) send_byte(8'($urandom));
  endtask

  task automatic test_random_stream();
    int start;
    start = items_sent;
    while (items_sent - start < RAND_ITEMS) begin
      if (items_sent - start > RAND_ITEMS - 60) quiet = 1'b1;
      send_random_command();
    end
    send_byte(CMD_END);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_each_command();
    test_far_copies();
    test_backpressure();
    test_random_stream();
    in_valid <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (60) @(posedge clk);
    $display("sent %0d compressed items, checked %0d results over %0d streams",
             items_sent, results_seen, streams_ended);
    $display("covered every command, far copies, restarts and a long output hold");
    if (errors == 0 && decoded_q.size() == 0)
      $display("lz_rle_delta_decompressor regression: pass");
    else
      $display("lz_rle_delta_decompressor regression: fail");
    $finish;
  end

endmodule
